// File: hw/rtl/fec_pkg.sv
package fec_pkg;

    // Widths of the item and result fields.
    localparam int COL_W   = 5;
    localparam int ROW_W   = 3;
    localparam int HEAT_W  = 8;
    localparam int MAX_ROWS = 8;

    // Value taken by the spark threshold register at reset.
    localparam logic [HEAT_W-1:0] SPARK_THRESHOLD_RESET = 8'd120;

    typedef logic [HEAT_W-1:0] heat_t;

    // One column of heat, row 0 in the lowest byte.
    typedef logic [MAX_ROWS-1:0][HEAT_W-1:0] heat_col_t;

    // Classified item as held in the queue between front and back.
    typedef struct packed {
        logic [COL_W-1:0] col;
        heat_col_t        cool;
        logic             spark;
        heat_t            spark_value;
    } fec_item_t;

    // Updated column handed from the back part to the pixel emitter.
    typedef struct packed {
        logic [COL_W-1:0] col;
        heat_col_t        heat;
    } fec_col_t;

endpackage

// File: hw/rtl/fec_front.sv
module fec_front
    import fec_pkg::*;
#(
    parameter int MATRIX_WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [COL_W-1:0] column,
    input  heat_col_t        cool,
    input  heat_t            spark_roll,
    input  heat_t            spark_value,
    output logic             q_valid,
    output fec_item_t        q_item,
    input  logic             q_pop
);

    heat_t      threshold_reg;
    fec_item_t  queue_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       accept;
    logic       push;
    logic       in_range;
    fec_item_t  new_item;

    assign cfg_ready  = 1'b1;
    assign item_stall = (count_reg == 2'd2);
    assign accept     = item_valid && !item_stall;

    // Items for a column outside the matrix are swallowed here.
    assign in_range = (32'(column) < 32'(MATRIX_WIDTH));
    assign push     = accept && in_range;

    assign new_item.col         = column;
    assign new_item.cool        = cool;
    assign new_item.spark       = (spark_roll < threshold_reg);
    assign new_item.spark_value = spark_value;

    assign q_valid = (count_reg != 2'd0);
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (q_pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= SPARK_THRESHOLD_RESET;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                threshold_reg <= cfg_data;
            end
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// File: hw/rtl/fec_back.sv
module fec_back
    import fec_pkg::*;
#(
    parameter int MATRIX_WIDTH  = 32,
    parameter int MATRIX_HEIGHT = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  fec_item_t q_item,
    output logic      q_pop,
    output logic      col_valid,
    output fec_col_t  col_data,
    input  logic      col_ready
);

    localparam int AW = (MATRIX_WIDTH > 1) ? $clog2(MATRIX_WIDTH) : 1;
    localparam int XW = (AW > COL_W) ? AW : COL_W;

    // Floor of d / 3 for d below 768, by multiplying with 683 / 2048.
    function automatic heat_t div3(input logic [9:0] d);
        logic [19:0] p;
        begin
            p = 20'(d) * 20'd683;
            return p[18:11];
        end
    endfunction

    heat_col_t              mem [MATRIX_WIDTH];
    logic [MATRIX_WIDTH-1:0] vld_reg;
    heat_col_t              rd_data_reg;
    logic                   rd_vld_reg;

    logic       s1_valid_reg;
    fec_item_t  s1_item_reg;
    logic       s2_valid_reg;
    logic [COL_W-1:0] s2_col_reg;
    logic       s2_spark_reg;
    heat_t      s2_spark_value_reg;
    heat_col_t  s2_heat_reg;

    logic [XW-1:0] rd_col_x;
    logic [XW-1:0] wr_col_x;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          s1_adv;
    logic          s2_adv;
    heat_col_t     base_heat;
    heat_col_t     cooled;
    heat_col_t     new_heat;

    assign rd_col_x = XW'(q_item.col);
    assign rd_addr  = rd_col_x[AW-1:0];
    assign wr_col_x = XW'(s2_col_reg);
    assign wr_addr  = wr_col_x[AW-1:0];

    // A read is only issued once the previous column has been written back.
    assign q_pop  = q_valid && !s1_valid_reg && !s2_valid_reg;
    assign s2_adv = s2_valid_reg && col_ready;
    assign s1_adv = s1_valid_reg && (!s2_valid_reg || s2_adv);

    assign base_heat = rd_vld_reg ? rd_data_reg : '0;

    for (genvar y = 0; y < MAX_ROWS; y++)
    begin : g_row
        if (y < MATRIX_HEIGHT)
        begin : g_cool
            assign cooled[y] = (s1_item_reg.cool[y] >= base_heat[y]) ? '0
                             : base_heat[y] - s1_item_reg.cool[y];
        end
        else
        begin : g_nocool
            assign cooled[y] = '0;
        end

        if (y < MATRIX_HEIGHT - 2)
        begin : g_drift
            logic [9:0] drift_sum;
            assign drift_sum = {1'b0, s2_heat_reg[y + 1], 1'b0} + 10'(s2_heat_reg[y + 2]);
            assign new_heat[y] = div3(drift_sum);
        end
        else if (y == MATRIX_HEIGHT - 2)
        begin : g_drift_low
            logic [9:0] drift_sum;
            assign drift_sum = {1'b0, s2_heat_reg[y], 1'b0} + 10'(s2_heat_reg[y + 1]);
            assign new_heat[y] = div3(drift_sum);
        end
        else if (y == MATRIX_HEIGHT - 1)
        begin : g_bottom
            logic [8:0] spark_sum;
            assign spark_sum = 9'(s2_heat_reg[y]) + 9'(s2_spark_value_reg);
            assign new_heat[y] = !s2_spark_reg ? s2_heat_reg[y]
                               : (spark_sum[8] ? '1 : spark_sum[HEAT_W-1:0]);
        end
        else
        begin : g_unused
            assign new_heat[y] = '0;
        end
    end

    assign col_valid     = s2_valid_reg;
    assign col_data.col  = s2_col_reg;
    assign col_data.heat = new_heat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (s2_adv)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (q_pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            mem[wr_addr] <= new_heat;
        end
        if (q_pop)
        begin
            rd_data_reg <= mem[rd_addr];
            s1_item_reg <= q_item;
        end
        if (s1_adv)
        begin
            s2_col_reg         <= s1_item_reg.col;
            s2_spark_reg       <= s1_item_reg.spark;
            s2_spark_value_reg <= s1_item_reg.spark_value;
            s2_heat_reg        <= cooled;
        end
    end

endmodule

// File: hw/rtl/fec_emit.sv
module fec_emit
    import fec_pkg::*;
#(
    parameter int MATRIX_HEIGHT = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             col_valid,
    input  fec_col_t         col_data,
    output logic             col_ready,
    output logic             pixel_valid,
    input  logic             pixel_stall,
    output logic [ROW_W-1:0] row,
    output logic [COL_W-1:0] pixel_column,
    output heat_t            red,
    output heat_t            green,
    output heat_t            blue,
    output logic             last
);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MATRIX_HEIGHT - 1);

    logic             em_valid_reg;
    logic [COL_W-1:0] em_col_reg;
    heat_col_t        em_heat_reg;
    logic [ROW_W-1:0] em_row_reg;

    logic             pixel_valid_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    heat_t            red_reg;
    heat_t            green_reg;
    heat_t            blue_reg;

    logic        out_free;
    logic        emit;
    heat_t       cur_heat;
    logic [15:0] scaled;
    logic [16:0] quot_sum;
    heat_t       t;
    heat_t       ramp;
    heat_t       red_next;
    heat_t       green_next;
    heat_t       blue_next;

    assign out_free  = !pixel_valid_reg || !pixel_stall;
    assign emit      = em_valid_reg && out_free;
    assign col_ready = !em_valid_reg || (out_free && (em_row_reg == LAST_ROW));

    // Black-body ramp: t = heat * 191 / 255, the division done exactly as
    // (x + x / 256 + 1) / 256 for every product x = heat * 191.
    assign cur_heat = em_heat_reg[em_row_reg];
    assign scaled   = 16'(cur_heat) * 16'd191;
    assign quot_sum = 17'(scaled) + 17'(scaled[15:8]) + 17'd1;
    assign t        = quot_sum[15:8];
    assign ramp     = {t[5:0], 2'b00};

    always_comb
    begin
        if (t[7])
        begin
            red_next   = '1;
            green_next = '1;
            blue_next  = ramp;
        end
        else if (t[6])
        begin
            red_next   = '1;
            green_next = ramp;
            blue_next  = '0;
        end
        else
        begin
            red_next   = ramp;
            green_next = '0;
            blue_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg    <= 1'b0;
            em_row_reg      <= '0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            if (col_valid && col_ready)
            begin
                em_valid_reg <= 1'b1;
                em_row_reg   <= '0;
            end
            else if (emit)
            begin
                if (em_row_reg == LAST_ROW)
                begin
                    em_valid_reg <= 1'b0;
                end
                em_row_reg <= em_row_reg + 1'b1;
            end
            if (out_free)
            begin
                pixel_valid_reg <= em_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_valid && col_ready)
        begin
            em_col_reg  <= col_data.col;
            em_heat_reg <= col_data.heat;
        end
        if (emit)
        begin
            row_reg   <= em_row_reg;
            col_reg   <= em_col_reg;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign pixel_valid  = pixel_valid_reg;
    assign row          = row_reg;
    assign pixel_column = col_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign last         = (row_reg == LAST_ROW);

endmodule

// File: hw/rtl/fire_effect_column_update.sv
// Fire effect column engine for a MATRIX_WIDTH x MATRIX_HEIGHT LED matrix.
// Each beat on the item channel carries one column number with its random
// draws; the block cools that column's stored heat row by row, lets the heat
// drift upward, optionally ignites a spark on the bottom row, writes the
// column back and then sends one pixel beat per row, row 0 first, with last
// set on the bottom row. Columns at or beyond MATRIX_WIDTH are accepted and
// dropped without any pixel beat. The heat store is all zero after reset.
// For the default matrix the throughput is set by the single pixel
// channel; after its item beat is taken, a lone column's first pixel
// passes through the store read, cooling, drift and write back and the
// colour lookup. The front queues up to two items while pixels of an
// earlier column are still going out, so the item channel only stalls
// when that queue is full. The spark threshold
// (reset value 120) is written over the cfg channel, which is always ready;
// write it only while no column is in flight.
module fire_effect_column_update
    import fec_pkg::*;
#(
    parameter int MATRIX_WIDTH  = 32,
    parameter int MATRIX_HEIGHT = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [7:0]       cfg_data,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [COL_W-1:0] column,
    input  heat_t            cool_row0,
    input  heat_t            cool_row1,
    input  heat_t            cool_row2,
    input  heat_t            cool_row3,
    input  heat_t            cool_row4,
    input  heat_t            cool_row5,
    input  heat_t            cool_row6,
    input  heat_t            cool_row7,
    input  heat_t            spark_roll,
    input  heat_t            spark_value,
    output logic             pixel_valid,
    input  logic             pixel_stall,
    output logic [ROW_W-1:0] row,
    output logic [COL_W-1:0] pixel_column,
    output heat_t            red,
    output heat_t            green,
    output heat_t            blue,
    output logic             last
);

    heat_col_t cool;
    logic      q_valid;
    fec_item_t q_item;
    logic      q_pop;
    logic      col_valid;
    fec_col_t  col_data;
    logic      col_ready;

    // Cooling amounts gathered into one word, row 0 in the lowest byte.
    assign cool = {cool_row7, cool_row6, cool_row5, cool_row4,
                   cool_row3, cool_row2, cool_row1, cool_row0};

    // The front takes item beats, drops out-of-range columns, evaluates the
    // spark condition against the threshold and queues the item.
    fec_front #(
        .MATRIX_WIDTH (MATRIX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .column      (column),
        .cool        (cool),
        .spark_roll  (spark_roll),
        .spark_value (spark_value),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // The back reads the column from the heat store, cools it in one stage,
    // applies drift and spark in the next and writes the result back.
    fec_back #(
        .MATRIX_WIDTH  (MATRIX_WIDTH),
        .MATRIX_HEIGHT (MATRIX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .col_valid (col_valid),
        .col_data  (col_data),
        .col_ready (col_ready)
    );

    // The emitter walks the rows of the updated column through the colour
    // ramp into the registered pixel channel.
    fec_emit #(
        .MATRIX_HEIGHT (MATRIX_HEIGHT)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .col_valid    (col_valid),
        .col_data     (col_data),
        .col_ready    (col_ready),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .row          (row),
        .pixel_column (pixel_column),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last         (last)
    );

endmodule
